// File: src/tps_pkg.sv
package tps_pkg;

    localparam int CW = 32;                         // coordinate width
    localparam int NW = 18;                         // normal component width
    localparam int OW = 32;                         // plane offset width
    localparam int TW = 31;                         // tolerance width
    localparam int PW = NW + CW;                    // one normal * coordinate product
    localparam int SW = PW + 2;                     // sum of three products
    localparam int DW = ((CW + 4 > OW) ? CW + 4 : OW) + 1;  // signed distance
    localparam int DDW = DW + 1;                    // distance difference
    localparam int RW = DDW + 1;                    // divider remainder
    localparam int QW = 16;                         // fraction bits
    localparam int UW = QW + 1;                     // ratio 0..1.0
    localparam int MW = CW + 1 + UW + 1;            // edge delta * ratio
    localparam int SQW = 2 * CW;                    // one squared term
    localparam int SQSW = SQW + 2;                  // sum of three squared terms

    localparam logic [UW-1:0] U_ONE = UW'(1) << QW;

    localparam int CFG_DW = 32;
    localparam int IW = 3;
    localparam logic [IW-1:0] REG_NORMAL_X = 3'd0;
    localparam logic [IW-1:0] REG_NORMAL_Y = 3'd1;
    localparam logic [IW-1:0] REG_NORMAL_Z = 3'd2;
    localparam logic [IW-1:0] REG_OFFSET   = 3'd3;
    localparam logic [IW-1:0] REG_TOL      = 3'd4;

    localparam int IN_DW = ((9 * CW + 7) / 8) * 8;
    localparam int OUT_BITS = 10 + 3 * CW + 3 * UW;
    localparam int OUT_DW = ((OUT_BITS + 7) / 8) * 8;

    localparam int QDEPTH = 2;
    localparam int QAW = 1;

    localparam logic [2:0] CORNER_V0 = 3'd0;
    localparam logic [2:0] CORNER_V1 = 3'd1;
    localparam logic [2:0] CORNER_V2 = 3'd2;
    localparam logic [2:0] CORNER_P3 = 3'd3;
    localparam logic [2:0] CORNER_P4 = 3'd4;

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic signed [OW-1:0] offset;
        logic [TW-1:0]        tol;
    } cfg_t;

    typedef enum logic [1:0] {
        SPLIT_NONE  = 2'd0,
        SPLIT_CUT_C = 2'd1,   // rotated vertex 1 on the plane, cut edge 0-2
        SPLIT_CUT_B = 2'd2,   // rotated vertex 2 on the plane, cut edge 0-1
        SPLIT_TWO   = 2'd3
    } split_t;

    typedef struct packed {
        split_t                split;
        logic [1:0]            i0;
        logic [1:0]            i1;
        logic [1:0]            i2;
        logic                  side;
        logic [2:0][2:0][CW-1:0] vert;   // rotated vertices, [vertex][axis]
        logic [2:0][DW-1:0]    vdist;    // rotated distances
    } task_t;

endpackage

// File: src/triangle_plane_splitter_core.sv
// Triangle plane splitter.
// Slave stream: one triangle per request, nine signed Q16.16 coordinates in
// s_axis_tdata (a.x, a.y, a.z, b.x ... c.z from the lowest bits up).
// Master stream: one to five results per triangle; tuser = 0 for a crossing
// point (point and barycentric weights), 1 for a sub-triangle (corner
// indices and side flag); tlast marks the final result of the triangle.
// Configuration: cfg_write/cfg_index/cfg_data write the plane normal, the
// offset and the tolerance; write only while the block is idle.
// The front end registers products and then distances, and then pushes a
// classified triangle into a two-entry queue. An unsplit triangle moves the
// back end from idle to emit and leaves one registered result; a split one
// first passes divider setup, the two-bit-per-cycle ratio dividers,
// interpolation and the diagonal compare, then emits one result per cycle
// while the master accepts. The back end takes a new triangle only after the
// last result of the one before; the ratio dividers set the rate for split
// triangles.
// Reset clears all handshake state and loads the default plane (z = 0).
// A stalled master holds its result; the queue then fills and the slave
// side drops tready.
module triangle_plane_splitter_core
    import tps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [IW-1:0]     cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x .. vertex_c_z
    input  logic [IN_DW-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // corner_first, corner_second, corner_third, on_positive, point_x,
    // point_y, point_z, bary_first, bary_second, bary_third, zero pad
    output logic [OUT_DW-1:0] m_axis_tdata,
    // kind
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);

    cfg_t  cfg_reg;
    logic  push;
    task_t push_data;
    logic  full;
    logic  pop;
    task_t pop_data;
    logic  empty;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nx     <= '0;
            cfg_reg.ny     <= '0;
            cfg_reg.nz     <= NW'(1) << QW;
            cfg_reg.offset <= '0;
            cfg_reg.tol    <= TW'(7);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NORMAL_X: cfg_reg.nx     <= cfg_data[NW-1:0];
                REG_NORMAL_Y: cfg_reg.ny     <= cfg_data[NW-1:0];
                REG_NORMAL_Z: cfg_reg.nz     <= cfg_data[NW-1:0];
                REG_OFFSET:   cfg_reg.offset <= cfg_data[OW-1:0];
                REG_TOL:      cfg_reg.tol    <= cfg_data[TW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: distances, classification, rotation.
    tps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    // Decouple the front end from the back end.
    tps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Back end: ratios, crossing points, sub-triangles.
    tps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .task_valid    (!empty),
        .task_data     (pop_data),
        .task_pop      (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: src/tps_front.sv
module tps_front
    import tps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_DW-1:0] s_axis_tdata,
    output logic             push,
    output task_t            push_data,
    input  logic             full
);

    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic signed [PW-1:0]    prod_reg [3][3];
    logic [2:0][2:0][CW-1:0] vert1_reg;
    logic [2:0][2:0][CW-1:0] vert2_reg;
    logic signed [DW-1:0]    dist_reg [3];

    logic s1_free;
    logic s2_free;
    logic [2:0] neg;
    logic [2:0] pos;
    logic [1:0] ncnt;
    logic [1:0] pcnt;
    logic [2:0] sel;
    logic [1:0] odd;
    logic       present;
    logic signed [DW-1:0] tol_s;

    assign push    = s2_valid_reg && !full;
    assign s2_free = !s2_valid_reg || push;
    assign s1_free = !s1_valid_reg || s2_free;
    assign s_axis_tready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1: nine products. Stage 2: distances.
    always_ff @(posedge clk)
    begin
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] shd;
        if (s1_free && s_axis_tvalid)
        begin
            for (int v = 0; v < 3; v++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    vert1_reg[v][c] <= s_axis_tdata[(3*v+c)*CW +: CW];
                end
                prod_reg[v][0] <= PW'(cfg.nx) * PW'($signed(s_axis_tdata[(3*v)*CW +: CW]));
                prod_reg[v][1] <= PW'(cfg.ny) * PW'($signed(s_axis_tdata[(3*v+1)*CW +: CW]));
                prod_reg[v][2] <= PW'(cfg.nz) * PW'($signed(s_axis_tdata[(3*v+2)*CW +: CW]));
            end
        end
        if (s2_free && s1_valid_reg)
        begin
            vert2_reg <= vert1_reg;
            for (int v = 0; v < 3; v++)
            begin
                sum = SW'(prod_reg[v][0]) + SW'(prod_reg[v][1]) + SW'(prod_reg[v][2]);
                shd = sum >>> QW;
                dist_reg[v] <= DW'(shd) - DW'(cfg.offset);
            end
        end
    end

    // Classify, find the odd vertex and rotate it first.
    assign tol_s = DW'($signed({1'b0, cfg.tol}));

    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            neg[v] = dist_reg[v] <= -tol_s;
            pos[v] = !neg[v] && (dist_reg[v] >= tol_s);
        end
        ncnt = {1'b0, neg[0]} + {1'b0, neg[1]} + {1'b0, neg[2]};
        pcnt = {1'b0, pos[0]} + {1'b0, pos[1]} + {1'b0, pos[2]};
        sel = (ncnt > pcnt) ? pos : neg;
        present = (|neg) && (|pos);
        if (sel[0])
            odd = 2'd0;
        else if (sel[1])
            odd = 2'd1;
        else
            odd = 2'd2;

        push_data.i0 = odd;
        case (odd)
            2'd0:
            begin
                push_data.i1 = 2'd1;
                push_data.i2 = 2'd2;
            end
            2'd1:
            begin
                push_data.i1 = 2'd2;
                push_data.i2 = 2'd0;
            end
            default:
            begin
                push_data.i1 = 2'd0;
                push_data.i2 = 2'd1;
            end
        endcase

        push_data.vert[0] = vert2_reg[push_data.i0];
        push_data.vert[1] = vert2_reg[push_data.i1];
        push_data.vert[2] = vert2_reg[push_data.i2];
        push_data.vdist[0] = dist_reg[push_data.i0];
        push_data.vdist[1] = dist_reg[push_data.i1];
        push_data.vdist[2] = dist_reg[push_data.i2];

        if (!present)
            push_data.split = SPLIT_NONE;
        else if (!neg[push_data.i1] && !pos[push_data.i1])
            push_data.split = SPLIT_CUT_C;
        else if (!neg[push_data.i2] && !pos[push_data.i2])
            push_data.split = SPLIT_CUT_B;
        else
            push_data.split = SPLIT_TWO;

        push_data.side = present ? pos[push_data.i0] : ~|neg;
    end

endmodule

// File: src/tps_queue.sv
module tps_queue
    import tps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_data,
    output logic  full,
    input  logic  pop,
    output task_t pop_data,
    output logic  empty
);

    task_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign full     = count_reg == (QAW+1)'(QDEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

// File: src/tps_back.sv
module tps_back
    import tps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              task_valid,
    input  task_t             task_data,
    output logic              task_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_PREP = 8'b0000_0010,
        ST_DIV  = 8'b0000_0100,
        ST_MUL  = 8'b0000_1000,
        ST_PT   = 8'b0001_0000,
        ST_SQ   = 8'b0010_0000,
        ST_CMP  = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic                  kind;
        logic [2:0]            c0;
        logic [2:0]            c1;
        logic [2:0]            c2;
        logic                  pos;
        logic [2:0][CW-1:0]    pt;
        logic [2:0][UW-1:0]    bary;
        logic                  last;
    } result_t;

    state_t              state_reg;
    task_t               task_reg;
    logic [2:0]          step_reg;
    logic [2:0]          div_cnt_reg;
    logic [DDW-1:0]      b_reg [2];
    logic [RW-1:0]       r_reg [2];
    logic [QW-1:0]       q_reg [2];
    logic                zero_reg [2];
    logic                sat_reg [2];
    logic signed [MW-1:0] prod_reg [2][3];
    logic [CW-1:0]       pt_reg [2][3];
    logic [SQW-1:0]      sq_reg [2][3];
    logic                near_reg;
    logic                m_valid_reg;
    result_t             out_reg;

    logic [UW-1:0] u [2];
    logic          load;
    result_t       res;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (zero_reg[k])
                u[k] = '0;
            else if (sat_reg[k])
                u[k] = U_ONE;
            else
                u[k] = {1'b0, q_reg[k]};
        end
    end

    assign load     = !m_valid_reg || m_axis_tready;
    assign task_pop = (state_reg == ST_IDLE) && task_valid;

    // Result for the current emit step.
    always_comb
    begin
        res = '0;
        case (task_reg.split)
            SPLIT_NONE:
            begin
                res.kind = 1'b1;
                res.c0 = CORNER_V0;
                res.c1 = CORNER_V1;
                res.c2 = CORNER_V2;
                res.pos = task_reg.side;
                res.last = 1'b1;
            end
            SPLIT_CUT_C:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        res.pt = {pt_reg[1][2], pt_reg[1][1], pt_reg[1][0]};
                        res.bary = {u[1], UW'(0), U_ONE - u[1]};
                    end
                    3'd1:
                    begin
                        res.kind = 1'b1;
                        res.c0 = {1'b0, task_reg.i0};
                        res.c1 = {1'b0, task_reg.i1};
                        res.c2 = CORNER_P3;
                        res.pos = task_reg.side;
                    end
                    default:
                    begin
                        res.kind = 1'b1;
                        res.c0 = {1'b0, task_reg.i1};
                        res.c1 = {1'b0, task_reg.i2};
                        res.c2 = CORNER_P3;
                        res.pos = !task_reg.side;
                        res.last = 1'b1;
                    end
                endcase
            end
            SPLIT_CUT_B:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        res.pt = {pt_reg[0][2], pt_reg[0][1], pt_reg[0][0]};
                        res.bary = {UW'(0), u[0], U_ONE - u[0]};
                    end
                    3'd1:
                    begin
                        res.kind = 1'b1;
                        res.c0 = {1'b0, task_reg.i0};
                        res.c1 = CORNER_P3;
                        res.c2 = {1'b0, task_reg.i2};
                        res.pos = task_reg.side;
                    end
                    default:
                    begin
                        res.kind = 1'b1;
                        res.c0 = {1'b0, task_reg.i2};
                        res.c1 = CORNER_P3;
                        res.c2 = {1'b0, task_reg.i1};
                        res.pos = !task_reg.side;
                        res.last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        res.pt = {pt_reg[0][2], pt_reg[0][1], pt_reg[0][0]};
                        res.bary = {UW'(0), u[0], U_ONE - u[0]};
                    end
                    3'd1:
                    begin
                        res.pt = {pt_reg[1][2], pt_reg[1][1], pt_reg[1][0]};
                        res.bary = {u[1], UW'(0), U_ONE - u[1]};
                    end
                    3'd2:
                    begin
                        res.kind = 1'b1;
                        res.c0 = {1'b0, task_reg.i0};
                        res.c1 = CORNER_P3;
                        res.c2 = CORNER_P4;
                        res.pos = task_reg.side;
                    end
                    3'd3:
                    begin
                        res.kind = 1'b1;
                        res.pos = !task_reg.side;
                        if (near_reg)
                        begin
                            res.c0 = CORNER_P3;
                            res.c1 = {1'b0, task_reg.i1};
                            res.c2 = {1'b0, task_reg.i2};
                        end
                        else
                        begin
                            res.c0 = CORNER_P4;
                            res.c1 = CORNER_P3;
                            res.c2 = {1'b0, task_reg.i1};
                        end
                    end
                    default:
                    begin
                        res.kind = 1'b1;
                        res.pos = !task_reg.side;
                        res.last = 1'b1;
                        if (near_reg)
                        begin
                            res.c0 = CORNER_P3;
                            res.c1 = {1'b0, task_reg.i2};
                            res.c2 = CORNER_P4;
                        end
                        else
                        begin
                            res.c0 = CORNER_P4;
                            res.c1 = {1'b0, task_reg.i1};
                            res.c2 = {1'b0, task_reg.i2};
                        end
                    end
                endcase
            end
        endcase
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                m_valid_reg <= (state_reg == ST_EMIT);
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (task_valid)
                        state_reg <= (task_data.split == SPLIT_NONE) ? ST_EMIT : ST_PREP;
                end
                ST_PREP:
                begin
                    div_cnt_reg <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 3'(QW / 2 - 1))
                        state_reg <= ST_MUL;
                end
                ST_MUL:  state_reg <= ST_PT;
                ST_PT:   state_reg <= ST_SQ;
                ST_SQ:   state_reg <= ST_CMP;
                ST_CMP:  state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    if (load)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (res.last)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath: ratio dividers, interpolation, diagonal lengths.
    always_ff @(posedge clk)
    begin
        logic signed [DDW-1:0] d0;
        logic signed [DDW-1:0] den;
        logic [DDW-1:0]        a;
        logic [DDW-1:0]        b;
        logic [RW-1:0]         t;
        logic [1:0]            bits;
        logic signed [CW:0]    diff;
        logic signed [MW-1:0]  s;
        logic [CW-1:0]         mag;
        logic [SQSW-1:0]       sum0;
        logic [SQSW-1:0]       sum1;
        if (task_pop)
            task_reg <= task_data;
        if (state_reg == ST_EMIT && load)
            out_reg <= res;
        case (state_reg)
            ST_PREP:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    d0  = DDW'($signed(task_reg.vdist[0]));
                    den = d0 - DDW'($signed(task_reg.vdist[k+1]));
                    a   = d0[DDW-1] ? DDW'(-d0) : DDW'(d0);
                    b   = den[DDW-1] ? DDW'(-den) : DDW'(den);
                    zero_reg[k] <= (den == '0) || (d0 == '0) || (d0[DDW-1] != den[DDW-1]);
                    sat_reg[k]  <= a >= b;
                    b_reg[k]    <= b;
                    r_reg[k]    <= RW'(a);
                    q_reg[k]    <= '0;
                end
            end
            ST_DIV:
            begin
                // Two restoring steps per cycle.
                for (int k = 0; k < 2; k++)
                begin
                    t = r_reg[k] << 1;
                    bits[1] = t >= RW'(b_reg[k]);
                    if (bits[1])
                        t = t - RW'(b_reg[k]);
                    t = t << 1;
                    bits[0] = t >= RW'(b_reg[k]);
                    if (bits[0])
                        t = t - RW'(b_reg[k]);
                    r_reg[k] <= t;
                    q_reg[k] <= {q_reg[k][QW-3:0], bits};
                end
            end
            ST_MUL:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        diff = (CW+1)'($signed(task_reg.vert[k+1][c]))
                             - (CW+1)'($signed(task_reg.vert[0][c]));
                        prod_reg[k][c] <= MW'(diff) * MW'($signed({1'b0, u[k]}));
                    end
                end
            end
            ST_PT:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        s = MW'($signed(task_reg.vert[0][c])) + (prod_reg[k][c] >>> QW);
                        pt_reg[k][c] <= s[CW-1:0];
                    end
                end
            end
            ST_SQ:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    diff = (CW+1)'($signed(pt_reg[0][c]))
                         - (CW+1)'($signed(task_reg.vert[2][c]));
                    mag = diff[CW] ? CW'(-diff) : CW'(diff);
                    sq_reg[0][c] <= SQW'(mag) * SQW'(mag);
                    diff = (CW+1)'($signed(task_reg.vert[1][c]))
                         - (CW+1)'($signed(pt_reg[1][c]));
                    mag = diff[CW] ? CW'(-diff) : CW'(diff);
                    sq_reg[1][c] <= SQW'(mag) * SQW'(mag);
                end
            end
            ST_CMP:
            begin
                sum0 = SQSW'(sq_reg[0][0]) + SQSW'(sq_reg[0][1]) + SQSW'(sq_reg[0][2]);
                sum1 = SQSW'(sq_reg[1][0]) + SQSW'(sq_reg[1][1]) + SQSW'(sq_reg[1][2]);
                near_reg <= sum0 <= sum1;
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = OUT_DW'({out_reg.bary[2], out_reg.bary[1], out_reg.bary[0],
                                    out_reg.pt[2], out_reg.pt[1], out_reg.pt[0],
                                    out_reg.pos, out_reg.c2, out_reg.c1, out_reg.c0});

endmodule
